### hw/rtl/lpr_pkg.sv
// shared widths and reset value for the lru page replacement block
`timescale 1ns / 1ps

package lpr_pkg;

	// capacity register
	localparam int unsigned CAP_W     = 5;
	localparam int unsigned CAP_RESET = 16;

	// running miss count
	localparam int unsigned MISS_W = 32;

endpackage

### hw/rtl/lru_page_replacement.sv
// fully associative lru page store with eviction report and miss count
`timescale 1ns / 1ps

// Fully associative LRU page store. Each accepted item is one page reference.
// The resident pages sit in a register stack ordered from least recent
// (entry 0) to most recent. Every reference is checked against all resident
// pages in parallel. A hit moves the page to the top. A miss with a free frame
// appends the page. A miss on a full store evicts and reports the least
// recent page. The frame count comes from the capacity register: zero acts as
// one, and values above ENTRIES act as ENTRIES. Lowering capacity below the
// current fill keeps all pages, and each later miss then evicts one.
// Throughput is one item per clock while the result channel does not stall.
// An accepted item goes into the input register; the compare-and-shift of the
// whole stack is combinational, its outcome held in the result register. Each
// result carries the miss count after its reference; the count wraps at 32 bits.
module lru_page_replacement #(
	parameter int unsigned ENTRIES   = 16,
	parameter int unsigned PAGE_BITS = 20
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        cfg_we,
	input  logic [lpr_pkg::CAP_W-1:0]   cfg_data,
	// reference channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [PAGE_BITS-1:0]        page,
	// result channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        hit,
	output logic                        evicted_valid,
	output logic [PAGE_BITS-1:0]        evicted_page,
	output logic [lpr_pkg::MISS_W-1:0]  miss_total
);

	localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
	localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CMP_W = (OCC_W > lpr_pkg::CAP_W) ? OCC_W : lpr_pkg::CAP_W;

	// state
	logic [PAGE_BITS-1:0]       stk_q [ENTRIES];
	logic [OCC_W-1:0]           occ_q;
	logic [lpr_pkg::MISS_W-1:0] miss_q;
	logic [lpr_pkg::CAP_W-1:0]  cap_q;

	// input register
	logic                 valid_s1;
	logic [PAGE_BITS-1:0] page_s1;

	// result register
	logic                       out_valid_s2;
	logic                       hit_s2;
	logic                       ev_valid_s2;
	logic [PAGE_BITS-1:0]       ev_page_s2;
	logic [lpr_pkg::MISS_W-1:0] miss_s2;

	// handshake
	logic in_acc;
	logic adv;

	assign adv      = valid_s1 && (!out_valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	// effective frame count
	logic [CMP_W-1:0] cap_ext;
	logic [CMP_W-1:0] eff_cap;
	logic [CMP_W-1:0] occ_ext;

	assign cap_ext = CMP_W'(cap_q);
	assign occ_ext = CMP_W'(occ_q);

	always_comb begin
		if (cap_ext == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
	end

	// parallel compare against resident pages, lowest match wins
	logic [ENTRIES-1:0] match;
	logic               hit_c;
	logic [IDX_W-1:0]   pos;

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = (CMP_W'(i) < occ_ext) && (stk_q[i] == page_s1);
		end
	end

	always_comb begin
		pos = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				pos = IDX_W'(i);
			end
		end
	end

	assign hit_c = |match;

	// miss handling
	logic                       full_c;
	logic                       evict_c;
	logic                       append_c;
	logic [CMP_W-1:0]           shift_from;
	logic [OCC_W-1:0]           occ_next;
	logic [lpr_pkg::MISS_W-1:0] miss_next;

	assign full_c     = !(occ_ext < eff_cap);
	assign evict_c    = !hit_c && full_c;
	assign append_c   = !hit_c && !full_c;
	assign shift_from = hit_c ? CMP_W'(pos) : '0;
	assign occ_next   = append_c ? occ_q + OCC_W'(1) : occ_q;
	assign miss_next  = hit_c ? miss_q : miss_q + lpr_pkg::MISS_W'(1);

	// next stack contents, one entry at a time
	logic [PAGE_BITS-1:0] stk_d  [ENTRIES];
	logic [ENTRIES-1:0]   stk_we;

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			stk_d[i]  = page_s1;
			stk_we[i] = 1'b0;
			if (append_c) begin
				stk_we[i] = (CMP_W'(i) == occ_ext);
			end else if (CMP_W'(i + 1) == occ_ext) begin
				// top of the stack takes the referenced page
				stk_we[i] = 1'b1;
			end else if ((CMP_W'(i) >= shift_from) && (CMP_W'(i + 1) < occ_ext)) begin
				// entries above the removed one move down
				stk_we[i] = 1'b1;
				if (i + 1 < ENTRIES) begin
					stk_d[i] = stk_q[(i + 1) % ENTRIES];
				end
			end
		end
	end

	// stack storage, payload only
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (stk_we[i]) begin
					stk_q[i] <= stk_d[i];
				end
			end
		end
	end

	// control state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			miss_q <= '0;
			cap_q  <= lpr_pkg::CAP_W'(lpr_pkg::CAP_RESET);
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (adv) begin
				occ_q  <= occ_next;
				miss_q <= miss_next;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			page_s1 <= page;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv) begin
			out_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s2      <= hit_c;
			ev_valid_s2 <= evict_c;
			ev_page_s2  <= evict_c ? stk_q[0] : '0;
			miss_s2     <= miss_next;
		end
	end

	assign out_valid     = out_valid_s2;
	assign hit           = hit_s2;
	assign evicted_valid = ev_valid_s2;
	assign evicted_page  = ev_page_s2;
	assign miss_total    = miss_s2;

`ifndef SYNTHESIS
	// fill never goes past the built stack
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(ENTRIES))
		else $error("occupancy above entry count");

	// a hit never evicts
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 |-> !(hit_s2 && ev_valid_s2))
		else $error("hit and eviction on one item");

	// evicted page reads zero without an eviction
	a_ev_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && !ev_valid_s2) |-> (ev_page_s2 == '0))
		else $error("evicted page not zero");

	// each miss bumps the counter by one
	a_miss_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !hit_c) |=> (miss_q == $past(miss_q) + lpr_pkg::MISS_W'(1)))
		else $error("miss count did not advance");

	// fill grows only on an append
	a_occ_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !append_c) |=> (occ_q == $past(occ_q)))
		else $error("occupancy changed without append");
`endif

endmodule
